@@ sv/mbps_pkg.sv @@
// Package for the masked byte pattern scan: register indexes, pattern sizes
// and the aligned-pattern bundle passed from the configuration block to the scanner.
// No dependencies.
package mbps_pkg;

  localparam int PATTERN_BYTES = 32;
  localparam int REG_BITS      = 64;
  localparam int LEN_BITS      = 6;
  localparam int RESULT_BITS   = 32;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_SECOND = 3'd1,
    REG_PATTERN_THIRD  = 3'd2,
    REG_PATTERN_HIGH   = 3'd3,
    REG_CARE_MASK      = 3'd4,
    REG_PATTERN_LENGTH = 3'd5
  } cfg_reg_t;

  // Pattern laid out against the window: lane w holds the pattern byte that
  // must sit at window age w. Lanes at or past the length have care clear.
  typedef struct packed {
    logic [PATTERN_BYTES-1:0][7:0] pat;
    logic [PATTERN_BYTES-1:0]      care;
    logic                          len_ok;
    logic [LEN_BITS-1:0]           len;
  } align_t;

endpackage

@@ sv/mbps_cfg.sv @@
// Configuration registers of the masked byte pattern scan, plus a registered
// copy of the pattern aligned to window ages. Depends on mbps_pkg.
module mbps_cfg import mbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [2:0]           wr_index,
  input  logic [REG_BITS-1:0]  wr_data,
  output align_t               aligned
);

  logic [3:0][REG_BITS-1:0]      pattern_words;
  logic [PATTERN_BYTES-1:0]      care_mask;
  logic [LEN_BITS-1:0]           pattern_length;
  logic [PATTERN_BYTES-1:0][7:0] pat_bytes;
  align_t                        aligned_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      care_mask      <= '0;
      pattern_length <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_PATTERN_LOW:    pattern_words[0] <= wr_data;
        REG_PATTERN_SECOND: pattern_words[1] <= wr_data;
        REG_PATTERN_THIRD:  pattern_words[2] <= wr_data;
        REG_PATTERN_HIGH:   pattern_words[3] <= wr_data;
        REG_CARE_MASK:      care_mask <= wr_data[PATTERN_BYTES-1:0];
        REG_PATTERN_LENGTH: pattern_length <= wr_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_bytes
    assign pat_bytes[j] = pattern_words[j / 8][(j % 8) * 8 +: 8];
  end

  // Lane w compares against pattern byte (length - 1 - w).
  always_comb begin
    logic [LEN_BITS-1:0] idx;
    aligned_next = '0;
    aligned_next.len = pattern_length;
    aligned_next.len_ok = (pattern_length != '0)
                       && ({1'b0, pattern_length} <= 7'(PATTERN_BYTES))
                       && ({1'b0, pattern_length} <= 7'(MAX_PATTERN_BYTES));
    for (int w = 0; w < PATTERN_BYTES; w++) begin
      idx = pattern_length - LEN_BITS'(w) - LEN_BITS'(1);
      if (LEN_BITS'(w) < pattern_length) begin
        aligned_next.pat[w]  = pat_bytes[idx[4:0]];
        aligned_next.care[w] = care_mask[idx[4:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aligned <= '0;
    end else begin
      aligned <= aligned_next;
    end
  end

endmodule

@@ sv/masked_byte_pattern_scan.sv @@
// Top level of the masked byte pattern scan: input register, byte window,
// offset counter, parallel masked compare and result register.
// Depends on mbps_pkg and mbps_cfg.
//
// Usage: bytes of a stream enter on the input channel (data_byte, last_byte),
// a request being taken at a rising edge with in_valid high and in_stall low.
// A byte in the input register is compared, and a result that it produces is
// loaded into the result register. One byte per cycle is sustained while no
// stalled result waits: the full window compare is a single registered pass of
// parallel byte comparators, and a byte that yields no result still advances.
// A result request (found, match_offset) is taken when out_valid is high and
// out_stall is low. While the result register is held by a stalled receiver,
// one more byte can wait in the input register; after that in_stall rises.
// The first match of a stream is reported once with the offset of its first
// byte; if the last byte arrives with no match, found 0 and offset 0 are
// reported. The window, counter and report flag clear after the last byte.
// Configuration writes are always ready and apply to bytes accepted after
// the write. Synchronous reset clears configuration, window and both stages.
module masked_byte_pattern_scan import mbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 32,
  parameter int OFFSET_BITS       = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input byte channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [RESULT_BITS-1:0] match_offset,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [REG_BITS-1:0]    cfg_data
);

  // Only window ages below the pattern register size can ever be compared.
  localparam int LANES = (MAX_PATTERN_BYTES < PATTERN_BYTES) ? MAX_PATTERN_BYTES
                                                              : PATTERN_BYTES;
  localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

  align_t aligned;

  // Input register.
  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       pend_last;

  // Stream state.
  logic [LANES-1:0][7:0]  window;
  logic [LANES-1:0][7:0]  window_next;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] cnt_next;
  logic [OFFSET_BITS-1:0] diff;
  logic                   reported;

  logic                   advance;
  logic                   in_take;
  logic [LANES-1:0]       lane_ok;
  logic                   cnt_ok;
  logic                   hit;
  logic                   produce;
  logic [RESULT_BITS-1:0] offset_clamped;
  logic [RESULT_BITS-1:0] offset_res;

  assign cfg_ready = 1'b1;

  mbps_cfg #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .aligned  (aligned)
  );

  // The compare stage moves whenever the result register is free or being
  // emptied this cycle.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = pend_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_take) begin
      pend_valid <= 1'b1;
    end else if (advance) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_byte <= data_byte;
      pend_last <= last_byte;
    end
  end

  // Window with the pending byte shifted in at age zero.
  always_comb begin
    window_next[0] = pend_byte;
    for (int i = 1; i < LANES; i++) begin
      window_next[i] = window[i-1];
    end
  end

  // Every lane either is a wildcard or matches its aligned pattern byte.
  always_comb begin
    for (int w = 0; w < LANES; w++) begin
      lane_ok[w] = !aligned.care[w] || (window_next[w] == aligned.pat[w]);
    end
  end

  // The counter saturates; a match seen while saturated reports all ones.
  assign cnt_next = (bytes_seen == CNT_MAX) ? bytes_seen : bytes_seen + OFFSET_BITS'(1);
  assign cnt_ok   = cnt_next >= OFFSET_BITS'(aligned.len);
  assign diff     = cnt_next - OFFSET_BITS'(aligned.len);

  if (OFFSET_BITS > RESULT_BITS) begin : g_clamp
    assign offset_clamped = (|diff[OFFSET_BITS-1:RESULT_BITS]) ? '1
                                                                : diff[RESULT_BITS-1:0];
  end else begin : g_extend
    assign offset_clamped = RESULT_BITS'(diff);
  end

  assign offset_res = (cnt_next == CNT_MAX) ? '1 : offset_clamped;
  assign hit        = !reported && aligned.len_ok && cnt_ok && (&lane_ok);
  assign produce    = hit || (pend_last && !reported);

  // Stream state advances with each byte and clears after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      bytes_seen <= '0;
      reported   <= 1'b0;
    end else if (pend_valid && advance) begin
      if (pend_last) begin
        window     <= '0;
        bytes_seen <= '0;
        reported   <= 1'b0;
      end else begin
        window     <= window_next;
        bytes_seen <= cnt_next;
        reported   <= reported || hit;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pend_valid && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend_valid && produce) begin
      found        <= hit;
      match_offset <= hit ? offset_res : '0;
    end
  end

`ifndef SYNTHESIS
  // A not-found result always carries a zero offset.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_offset == '0))
    else $error("not-found result with nonzero offset");

  // The input side only stalls while a byte waits in the input register.
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> pend_valid)
    else $error("input stalled with empty input register");

  // Processing a last byte returns the stream state to its start.
  a_stream_clear: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && advance && pend_last) |=> (bytes_seen == '0 && !reported))
    else $error("stream state not cleared after last byte");

  // A match within the stream blocks any further report until its end.
  a_hit_marks: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && advance && hit && !pend_last) |=> (reported && out_valid && found))
    else $error("match not recorded");
`endif

endmodule
